>>> design/iovapt_pkg.sv
// ----------------------------------------------------------------------------
// iovapt_pkg
// Types, codes and helpers for the two-level IOVA page table.
// ----------------------------------------------------------------------------
package iovapt_pkg;

  localparam int IovaW     = 38;
  localparam int PageW     = 30;
  localparam int Page26W   = 26;
  localparam int OffsetW   = 14;
  localparam int IndexW    = 11;
  localparam int RootW     = 2;
  localparam int PaddrW    = 44;
  localparam int FuncW     = 2;
  localparam int StatusW   = 3;
  localparam int L1Entries = 2048;
  localparam int L2Entries = 2048;

  localparam int RootLsb   = 36;
  localparam int L1IdxLsb  = 25;
  localparam int L2IdxLsb  = 14;

  localparam logic [FuncW-1:0] FuncTranslate = 2'd0;
  localparam logic [FuncW-1:0] FuncMap       = 2'd1;
  localparam logic [FuncW-1:0] FuncUnmap     = 2'd2;

  localparam logic [StatusW-1:0] StatusOk        = 3'd0;
  localparam logic [StatusW-1:0] StatusL1Fault   = 3'd1;
  localparam logic [StatusW-1:0] StatusL2Fault   = 3'd2;
  localparam logic [StatusW-1:0] StatusMapped    = 3'd3;
  localparam logic [StatusW-1:0] StatusPoolEmpty = 3'd4;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [IovaW-1:0] iova;
    logic [PageW-1:0] phys_page;
  } in_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [PaddrW-1:0]  phys_addr;
  } out_t;

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StLevel1,
    StLevel2
  } state_e;

  // Truncate a page number to the width of the selected entry format.
  function automatic logic [PageW-1:0] page_trunc(input logic [PageW-1:0] page,
                                                  input logic             fmt30);
    logic [PageW-1:0] res;
    res = fmt30 ? page : {{(PageW - Page26W){1'b0}}, page[Page26W-1:0]};
    return res;
  endfunction

endpackage

>>> design/iovapt_ram.sv
// ----------------------------------------------------------------------------
// iovapt_ram
// Single-clock memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module iovapt_ram #(
  parameter int Width = 8,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/iova_two_level_page_table.sv
// ----------------------------------------------------------------------------
// iova_two_level_page_table
// Two-level device address translation table: translate, map or unmap one
// 16 KiB page per transaction. The level-1 entry is read from its memory,
// the level-2 entry is read from the second memory at the address the first
// read yields, and the result is registered while any entry update is
// written back. A finished result waits in the output register, so the next
// transaction is taken while it is held. After reset a clearing pass over
// max(ROOT_COUNT, L2_TABLES) * 2048 addresses (8192 at the default sizes)
// invalidates both tables; no transaction is accepted during it,
// configuration writes are.
// ----------------------------------------------------------------------------
module iova_two_level_page_table #(
  parameter int ROOT_COUNT = 4,
  parameter int L2_TABLES  = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  iovapt_pkg::in_t    in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output iovapt_pkg::out_t   out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i
);

  localparam int L1Depth  = ROOT_COUNT * iovapt_pkg::L1Entries;
  localparam int L2Depth  = L2_TABLES * iovapt_pkg::L2Entries;
  localparam int L1AW     = $clog2(L1Depth);
  localparam int L2AW     = $clog2(L2Depth);
  localparam int TW       = (L2_TABLES > 1) ? $clog2(L2_TABLES) : 1;
  localparam int UW       = $clog2(L2_TABLES + 1);
  localparam int L1W      = 1 + TW;
  localparam int L2W      = 1 + iovapt_pkg::PageW;
  localparam int ClrDepth = (L1Depth > L2Depth) ? L1Depth : L2Depth;
  localparam int ClrW     = $clog2(ClrDepth);
  localparam int A1FullW  = iovapt_pkg::RootW + iovapt_pkg::IndexW;
  localparam int A2FullW  = TW + iovapt_pkg::IndexW;

  iovapt_pkg::state_e state_q, state_d;
  logic [ClrW-1:0]    clr_q, clr_d;
  logic [UW-1:0]      tables_used_q, tables_used_d;
  logic               pte_format_q;
  iovapt_pkg::in_t    in_q;
  logic               out_valid_q, out_valid_d;
  iovapt_pkg::out_t   out_data_q, out_data_d;

  logic               l1_we, l1_re;
  logic [L1AW-1:0]    l1_waddr, l1_raddr;
  logic [L1W-1:0]     l1_wdata, l1_rdata;
  logic               l2_we, l2_re;
  logic [L2AW-1:0]    l2_waddr, l2_raddr;
  logic [L2W-1:0]     l2_wdata, l2_rdata;

  logic                                 in_acc;
  logic                                 finish;
  logic [A1FullW-1:0]                   a1_in_full, a1_q_full;
  logic [A2FullW-1:0]                   a2_full;
  logic [L2AW-1:0]                      a2;
  logic [iovapt_pkg::RootW-1:0]         root;
  logic                                 root_ok;
  logic                                 have_l1;
  logic                                 pool_ok;
  logic [TW-1:0]                        l2_table;
  logic [iovapt_pkg::PageW-1:0]         l2_page;
  logic                                 l2_valid;
  logic [iovapt_pkg::PageW-1:0]         pn_trunc;
  logic [iovapt_pkg::StatusW-1:0]       res_status;
  logic [iovapt_pkg::PaddrW-1:0]        res_paddr;
  logic                                 res_l1_wr, res_l2_wr, res_alloc;
  logic [L2W-1:0]                       res_l2_wdata;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != iovapt_pkg::StIdle);
  assign in_acc      = in_valid_i && (state_q == iovapt_pkg::StIdle);
  assign finish      = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Address and entry decode
  assign a1_in_full = {in_data_i.iova[iovapt_pkg::RootLsb +: iovapt_pkg::RootW],
                       in_data_i.iova[iovapt_pkg::L1IdxLsb +: iovapt_pkg::IndexW]};
  assign a1_q_full  = {in_q.iova[iovapt_pkg::RootLsb +: iovapt_pkg::RootW],
                       in_q.iova[iovapt_pkg::L1IdxLsb +: iovapt_pkg::IndexW]};
  assign root       = in_q.iova[iovapt_pkg::RootLsb +: iovapt_pkg::RootW];
  assign root_ok    = {1'b0, root} < 3'(ROOT_COUNT);
  assign have_l1    = root_ok && l1_rdata[L1W-1];
  assign pool_ok    = tables_used_q < UW'(L2_TABLES);
  assign l2_table   = have_l1 ? l1_rdata[TW-1:0] : tables_used_q[TW-1:0];
  assign a2_full    = {l2_table, in_q.iova[iovapt_pkg::L2IdxLsb +: iovapt_pkg::IndexW]};
  assign a2         = a2_full[L2AW-1:0];
  assign l2_valid   = l2_rdata[L2W-1];
  assign l2_page    = l2_rdata[iovapt_pkg::PageW-1:0];
  assign pn_trunc   = iovapt_pkg::page_trunc(in_q.phys_page, pte_format_q);

  // Transaction result and entry updates
  always_comb begin
    res_status   = iovapt_pkg::StatusOk;
    res_paddr    = '0;
    res_l1_wr    = 1'b0;
    res_l2_wr    = 1'b0;
    res_alloc    = 1'b0;
    res_l2_wdata = '0;
    case (in_q.func)
      iovapt_pkg::FuncTranslate: begin
        if (!have_l1) begin
          res_status = iovapt_pkg::StatusL1Fault;
        end else if (!l2_valid) begin
          res_status = iovapt_pkg::StatusL2Fault;
        end else begin
          res_paddr = {iovapt_pkg::page_trunc(l2_page, pte_format_q),
                       in_q.iova[iovapt_pkg::OffsetW-1:0]};
        end
      end
      iovapt_pkg::FuncMap: begin
        if (!root_ok) begin
          res_status = iovapt_pkg::StatusL1Fault;
        end else if (!have_l1) begin
          if (!pool_ok) begin
            res_status = iovapt_pkg::StatusPoolEmpty;
          end else begin
            res_l1_wr    = 1'b1;
            res_alloc    = 1'b1;
            res_l2_wr    = 1'b1;
            res_l2_wdata = {1'b1, pn_trunc};
          end
        end else if (l2_valid) begin
          res_status = iovapt_pkg::StatusMapped;
        end else begin
          res_l2_wr    = 1'b1;
          res_l2_wdata = {1'b1, pn_trunc};
        end
      end
      iovapt_pkg::FuncUnmap: begin
        res_l2_wr = have_l1;
      end
      default: begin
        res_status = iovapt_pkg::StatusOk;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      iovapt_pkg::StClear: begin
        if (clr_q == ClrW'(ClrDepth - 1)) begin
          state_d = iovapt_pkg::StIdle;
        end
      end
      iovapt_pkg::StIdle: begin
        if (in_acc) begin
          state_d = iovapt_pkg::StLevel1;
        end
      end
      iovapt_pkg::StLevel1: begin
        state_d = iovapt_pkg::StLevel2;
      end
      iovapt_pkg::StLevel2: begin
        if (finish) begin
          state_d = iovapt_pkg::StIdle;
        end
      end
      default: begin
        state_d = iovapt_pkg::StClear;
      end
    endcase
  end

  // Outputs: memory ports, counters, result register
  always_comb begin
    l1_we         = 1'b0;
    l1_waddr      = a1_q_full[L1AW-1:0];
    l1_wdata      = {1'b1, tables_used_q[TW-1:0]};
    l1_re         = 1'b0;
    l1_raddr      = a1_in_full[L1AW-1:0];
    l2_we         = 1'b0;
    l2_waddr      = a2;
    l2_wdata      = res_l2_wdata;
    l2_re         = 1'b0;
    l2_raddr      = a2;
    clr_d         = clr_q;
    tables_used_d = tables_used_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_data_d    = out_data_q;
    unique case (state_q)
      iovapt_pkg::StClear: begin
        l1_we    = {1'b0, clr_q} < (ClrW + 1)'(L1Depth);
        l1_waddr = clr_q[L1AW-1:0];
        l1_wdata = '0;
        l2_we    = {1'b0, clr_q} < (ClrW + 1)'(L2Depth);
        l2_waddr = clr_q[L2AW-1:0];
        l2_wdata = '0;
        clr_d    = clr_q + ClrW'(1);
      end
      iovapt_pkg::StIdle: begin
        l1_re = in_acc;
      end
      iovapt_pkg::StLevel1: begin
        l2_re = 1'b1;
      end
      iovapt_pkg::StLevel2: begin
        if (finish) begin
          l1_we                = res_l1_wr;
          l2_we                = res_l2_wr;
          out_valid_d          = 1'b1;
          out_data_d.status    = res_status;
          out_data_d.phys_addr = res_paddr;
          if (res_alloc) begin
            tables_used_d = tables_used_q + UW'(1);
          end
        end
      end
      default: begin
        clr_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= iovapt_pkg::StClear;
      clr_q         <= '0;
      tables_used_q <= '0;
      pte_format_q  <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      clr_q         <= clr_d;
      tables_used_q <= tables_used_d;
      out_valid_q   <= out_valid_d;
      if (cfg_valid_i) begin
        pte_format_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (in_acc) begin
      in_q <= in_data_i;
    end
  end

  iovapt_ram #(
    .Width (L1W),
    .Depth (L1Depth)
  ) u_l1_ram (
    .clk_i   (clk_i),
    .we_i    (l1_we),
    .waddr_i (l1_waddr),
    .wdata_i (l1_wdata),
    .re_i    (l1_re),
    .raddr_i (l1_raddr),
    .rdata_o (l1_rdata)
  );

  iovapt_ram #(
    .Width (L2W),
    .Depth (L2Depth)
  ) u_l2_ram (
    .clk_i   (clk_i),
    .we_i    (l2_we),
    .waddr_i (l2_waddr),
    .wdata_i (l2_wdata),
    .re_i    (l2_re),
    .raddr_i (l2_raddr),
    .rdata_o (l2_rdata)
  );

endmodule

>>> dv/iova_two_level_page_table_tb.sv
// ----------------------------------------------------------------------------
// iova_two_level_page_table testbench
// Drives translate, map and unmap transactions through the two-level page
// table under random sender bursts and receiver stalls. Each accepted request
// is run through a behavioural copy of both tables and the pool inside a
// scoreboard, and every result is checked field by field in order. A directed
// opening covers faults, pool exhaustion, remapping and format changes. Random
// phases follow, mostly aimed at the allocated level-1 slots.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import iovapt_pkg::*;

  localparam int ROOT_COUNT = 4;
  localparam int L2_TABLES  = 4;
  localparam int ClkPeriod  = 8;
  localparam int CycleLimit = 400000;
  localparam int LongHold   = 300;
  localparam int DrainWait  = 20;
  localparam int RandPhases = 6;
  localparam int PhaseItems = 100;

  localparam logic [FuncW-1:0] FuncSpare = 2'd3;

  class page_table_scoreboard;
    bit              l1_valid [ROOT_COUNT*L1Entries];
    int unsigned     l1_table [ROOT_COUNT*L1Entries];
    bit              l2_valid [L2_TABLES*L2Entries];
    logic [PageW-1:0] l2_page [L2_TABLES*L2Entries];
    int unsigned     tables_used;
    bit              fmt30;
    out_t            pending_outcomes[$];
    int              errors;
    int              requests;
    int              outcomes;
    int              status_seen [8];

    function logic [PageW-1:0] narrow_page(logic [PageW-1:0] pg);
      return fmt30 ? pg : {{(PageW - Page26W){1'b0}}, pg[Page26W-1:0]};
    endfunction

    function void note_request(in_t item);
      logic [RootW-1:0]  root;
      logic [IndexW-1:0] i1;
      logic [IndexW-1:0] i2;
      int unsigned       a1;
      int unsigned       a2;
      bit                root_ok;
      bit                have_l1;
      out_t              res;
      root = item.iova[RootLsb +: RootW];
      i1 = item.iova[L1IdxLsb +: IndexW];
      i2 = item.iova[L2IdxLsb +: IndexW];
      res = '0;
      res.status = StatusOk;
      root_ok = int'(root) < ROOT_COUNT;
      a1 = root_ok ? int'(root) * L1Entries + int'(i1) : 0;
      have_l1 = root_ok && l1_valid[a1];
      a2 = have_l1 ? l1_table[a1] * L2Entries + int'(i2) : 0;
      case (item.func)
        FuncTranslate: begin
          if (!have_l1) begin
            res.status = StatusL1Fault;
          end else if (!l2_valid[a2]) begin
            res.status = StatusL2Fault;
          end else begin
            res.phys_addr = {narrow_page(l2_page[a2]), item.iova[OffsetW-1:0]};
          end
        end
        FuncMap: begin
          if (!root_ok) begin
            res.status = StatusL1Fault;
          end else begin
            if (!have_l1) begin
              if (tables_used >= L2_TABLES) begin
                res.status = StatusPoolEmpty;
              end else begin
                l1_valid[a1] = 1'b1;
                l1_table[a1] = tables_used;
                a2 = tables_used * L2Entries + int'(i2);
                tables_used++;
                have_l1 = 1'b1;
              end
            end
            if (have_l1) begin
              if (l2_valid[a2]) begin
                res.status = StatusMapped;
              end else begin
                l2_valid[a2] = 1'b1;
                l2_page[a2] = narrow_page(item.phys_page);
              end
            end
          end
        end
        FuncUnmap: begin
          if (have_l1) begin
            l2_valid[a2] = 1'b0;
            l2_page[a2] = '0;
          end
        end
        default: begin
        end
      endcase
      requests++;
      pending_outcomes.push_back(res);
    endfunction

    function void check_outcome(out_t got);
      out_t want;
      outcomes++;
      status_seen[got.status]++;
      if (pending_outcomes.size() == 0) begin
        $error("unexpected result: status %0d phys_addr 0x%0h", got.status, got.phys_addr);
        errors++;
        return;
      end
      want = pending_outcomes.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.phys_addr !== want.phys_addr) begin
        $error("phys_addr: expected 0x%0h, actual 0x%0h", want.phys_addr, got.phys_addr);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic cfg_data_i;

  page_table_scoreboard sb = new();

  int cycles;
  int burst_left;
  bit long_hold_req;
  int hold_left;
  int stall_mode;
  int stall_mode_left;

  iova_two_level_page_table #(
    .ROOT_COUNT(ROOT_COUNT),
    .L2_TABLES (L2_TABLES)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_outcome(out_data_o);
    end
  end

  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LongHold;
      end
      if (stall_mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_mode_left = $urandom_range(20, 200);
      end
      stall_mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 1) == 0);
          default: out_stall_i <= ($urandom_range(0, 9) < 8);
        endcase
      end
    end
  end

  function automatic logic [RootW+IndexW-1:0] hot_prefix(int k);
    case (k)
      0: return {2'd0, 11'h000};
      1: return {2'd3, 11'h7ff};
      2: return {2'd1, 11'h2aa};
      default: return {2'd2, 11'h555};
    endcase
  endfunction

  function automatic in_t make_item(logic [FuncW-1:0] func, logic [RootW+IndexW-1:0] prefix,
                                    logic [IndexW-1:0] i2, logic [OffsetW-1:0] offset,
                                    logic [PageW-1:0] page);
    in_t it;
    it.func = func;
    it.iova = {prefix, i2, offset};
    it.phys_page = page;
    return it;
  endfunction

  function automatic in_t random_item();
    in_t it;
    int  pick;
    it.iova[31:0] = $urandom;
    it.iova[IovaW-1:32] = 6'($urandom);
    it.phys_page = PageW'($urandom);
    case ($urandom_range(0, 9))
      0: it.phys_page = '1;
      1: it.phys_page = '0;
      default: begin
      end
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      it.func = FuncTranslate;
    end else if (pick < 70) begin
      it.func = FuncMap;
    end else if (pick < 95) begin
      it.func = FuncUnmap;
    end else begin
      it.func = FuncSpare;
    end
    if ($urandom_range(0, 9) < 8) begin
      it.iova[L1IdxLsb +: RootW+IndexW] = hot_prefix($urandom_range(0, 3));
      if ($urandom_range(0, 3) != 0) begin
        it.iova[L2IdxLsb +: IndexW] = IndexW'($urandom_range(0, 15));
      end
    end
    return it;
  endfunction

  task automatic send_item(input in_t item);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(item);
  endtask

  task automatic drain_outcomes();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_format(input logic fmt30);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= fmt30;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.fmt30 = fmt30;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_format(1'b0);
    send_item(make_item(FuncTranslate, hot_prefix(0), 11'h000, 14'h0000, '0));
    send_item(make_item(FuncUnmap, hot_prefix(0), 11'h000, 14'h0000, '0));
    send_item(make_item(FuncMap, hot_prefix(0), 11'h000, 14'h3fff, '1));
    send_item(make_item(FuncTranslate, hot_prefix(0), 11'h000, 14'h3fff, '0));
    send_item(make_item(FuncMap, hot_prefix(0), 11'h000, 14'h0000, '0));
    send_item(make_item(FuncTranslate, hot_prefix(0), 11'h001, 14'h0000, '0));
    send_item(make_item(FuncMap, hot_prefix(1), 11'h7ff, 14'h0000, '0));
    send_item(make_item(FuncTranslate, hot_prefix(1), 11'h7ff, 14'h0000, '0));
    send_item(make_item(FuncMap, hot_prefix(2), 11'h155, 14'h2aaa, 30'h2aaaaaaa));
    send_item(make_item(FuncMap, hot_prefix(3), 11'h2aa, 14'h1555, 30'h15555555));
    send_item(make_item(FuncMap, 13'h0abc, 11'h000, 14'h0000, '1));
    send_item(make_item(FuncTranslate, 13'h0abc, 11'h000, 14'h0000, '0));
    send_item(make_item(FuncUnmap, 13'h0abc, 11'h000, 14'h0000, '0));
    send_item(make_item(FuncUnmap, hot_prefix(0), 11'h000, 14'h0000, '0));
    send_item(make_item(FuncTranslate, hot_prefix(0), 11'h000, 14'h0000, '0));
    send_item(make_item(FuncUnmap, hot_prefix(0), 11'h005, 14'h0000, '0));
    send_item(make_item(FuncSpare, '1, '1, '1, '1));
    send_item(make_item(FuncMap, hot_prefix(0), 11'h000, 14'h0000, '1));
    send_item(make_item(FuncMap, hot_prefix(3), 11'h7ff, 14'h3fff, '1));
    drain_outcomes();

    write_format(1'b1);
    send_item(make_item(FuncTranslate, hot_prefix(0), 11'h000, 14'h1234, '0));
    send_item(make_item(FuncMap, hot_prefix(1), 11'h000, 14'h0000, '1));
    send_item(make_item(FuncTranslate, hot_prefix(1), 11'h000, 14'h3fff, '0));
    drain_outcomes();

    write_format(1'b0);
    send_item(make_item(FuncTranslate, hot_prefix(1), 11'h000, 14'h3fff, '0));
    drain_outcomes();

    for (int phase = 0; phase < RandPhases; phase++) begin
      write_format(phase[0] ? 1'b0 : 1'b1);
      if (phase == 2 || phase == 4) begin
        long_hold_req = 1'b1;
      end
      for (int n = 0; n < PhaseItems; n++) begin
        send_item(random_item());
      end
      drain_outcomes();
    end

    repeat (DrainWait) @(posedge clk_i);
    if (sb.pending_outcomes.size() != 0) begin
      $error("%0d results never arrived", sb.pending_outcomes.size());
      sb.errors++;
    end
    $display("Ran %0d page table requests, %0d results checked in %0d cycles.",
             sb.requests, sb.outcomes, cycles);
    $display("Status mix: ok %0d, L1 fault %0d, L2 fault %0d, mapped %0d, pool empty %0d.",
             sb.status_seen[StatusOk], sb.status_seen[StatusL1Fault],
             sb.status_seen[StatusL2Fault], sb.status_seen[StatusMapped],
             sb.status_seen[StatusPoolEmpty]);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
